// ===== rtl/clex_pkg.sv =====
`default_nettype none
package clex_pkg;

    // Scanner states
    typedef enum logic [4:0] {
        ST_START, ST_IDENT, ST_INT, ST_DOT, ST_FRAC, ST_EXP, ST_SIGN, ST_EXPD,
        ST_LT, ST_GT, ST_AMP, ST_BAR, ST_ARITH, ST_SLASH, ST_LCOM, ST_BCOM,
        ST_STAR, ST_EQ, ST_BANG, ST_STR, ST_CHR, ST_PRE
    } scan_t;

    // Sequencer states
    typedef enum logic [2:0] {
        F_IDLE, F_STEP, F_KW, F_SRD, F_SCMP, F_FIN, F_EMIT
    } fsm_t;

    // Token kinds
    localparam logic [3:0] K_KW      = 4'd0;
    localparam logic [3:0] K_ID      = 4'd1;
    localparam logic [3:0] K_NUM     = 4'd2;
    localparam logic [3:0] K_DELIM   = 4'd3;
    localparam logic [3:0] K_RELOP   = 4'd4;
    localparam logic [3:0] K_SHIFT   = 4'd5;
    localparam logic [3:0] K_LOGIC   = 4'd6;
    localparam logic [3:0] K_ADDR    = 4'd7;
    localparam logic [3:0] K_ASSIGN  = 4'd8;
    localparam logic [3:0] K_OP      = 4'd9;
    localparam logic [3:0] K_COMMENT = 4'd10;
    localparam logic [3:0] K_STR     = 4'd11;
    localparam logic [3:0] K_CHR     = 4'd12;
    localparam logic [3:0] K_PRE     = 4'd13;
    localparam logic [3:0] K_ERROR   = 4'd14;

    // Error codes
    localparam logic [3:0] E_NONE     = 4'd0;
    localparam logic [3:0] E_ID_DIGIT = 4'd1;
    localparam logic [3:0] E_NO_FRAC  = 4'd2;
    localparam logic [3:0] E_NO_EXP   = 4'd3;
    localparam logic [3:0] E_BAD_EXP  = 4'd4;
    localparam logic [3:0] E_BAR      = 4'd5;
    localparam logic [3:0] E_BANG     = 4'd6;
    localparam logic [3:0] E_UNKNOWN  = 4'd7;
    localparam logic [3:0] E_OVERFLOW = 4'd8;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;

    // One result item without its line number
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] detail;
        logic [7:0] second;
        logic [7:0] len;
        logic [6:0] sym;
        logic       fresh;
        logic [3:0] err;
    } res_t;

    // Outcome of a byte seen from the start state
    typedef struct packed {
        logic  emit;
        res_t  res;
        logic  begin_tok;
        scan_t st;
    } start_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return (c inside {[8'h30:8'h39]});
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_num(c) || (c == CH_UNDER);
    endfunction

    function automatic res_t mk_res(input logic [3:0] kind, input logic [7:0] detail,
                                    input logic [7:0] second, input logic [7:0] len,
                                    input logic [3:0] err);
        res_t r;
        r.kind   = kind;
        r.detail = detail;
        r.second = second;
        r.len    = len;
        r.sym    = 7'd0;
        r.fresh  = 1'b0;
        r.err    = err;
        return r;
    endfunction

    // Keyword spelling, first character in the highest used byte
    function automatic logic [63:0] kw_word(input logic [5:0] idx);
        logic [63:0] w;
        case (idx)
            6'd0:  w = 64'("int");
            6'd1:  w = 64'("long");
            6'd2:  w = 64'("short");
            6'd3:  w = 64'("float");
            6'd4:  w = 64'("double");
            6'd5:  w = 64'("char");
            6'd6:  w = 64'("unsigned");
            6'd7:  w = 64'("signed");
            6'd8:  w = 64'("const");
            6'd9:  w = 64'("void");
            6'd10: w = 64'("struct");
            6'd11: w = 64'("union");
            6'd12: w = 64'("if");
            6'd13: w = 64'("else");
            6'd14: w = 64'("goto");
            6'd15: w = 64'("switch");
            6'd16: w = 64'("case");
            6'd17: w = 64'("do");
            6'd18: w = 64'("while");
            6'd19: w = 64'("for");
            6'd20: w = 64'("continue");
            6'd21: w = 64'("break");
            6'd22: w = 64'("return");
            6'd23: w = 64'("default");
            6'd24: w = 64'("typedef");
            6'd25: w = 64'("extern");
            6'd26: w = 64'("static");
            6'd27: w = 64'("main");
            default: w = 64'd0;
        endcase
        return w;
    endfunction

    function automatic logic [3:0] kw_len(input logic [63:0] w);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < 8; k++) begin
            if (w[8*k +: 8] != 8'd0) n = 4'(k + 1);
        end
        return n;
    endfunction

    // Handle a byte from the start state
    function automatic start_t start_fn(input logic [7:0] c);
        start_t s;
        s.emit      = 1'b0;
        s.res       = mk_res(K_DELIM, c, 8'd0, 8'd1, E_NONE);
        s.begin_tok = 1'b1;
        s.st        = ST_START;
        if (c == CH_NUL || c == CH_SP || c == CH_TAB || c == CH_NL) begin
            s.begin_tok = 1'b0;
        end else if (is_alpha(c) || c == CH_UNDER) begin
            s.st = ST_IDENT;
        end else if (is_num(c)) begin
            s.st = ST_INT;
        end else begin
            case (c)
                CH_LT:    s.st = ST_LT;
                CH_GT:    s.st = ST_GT;
                CH_AMP:   s.st = ST_AMP;
                CH_BAR:   s.st = ST_BAR;
                CH_PLUS, CH_MINUS, CH_STAR, CH_PCT: s.st = ST_ARITH;
                CH_SLASH: s.st = ST_SLASH;
                CH_EQ:    s.st = ST_EQ;
                CH_BANG:  s.st = ST_BANG;
                CH_DQ:    s.st = ST_STR;
                CH_SQ:    s.st = ST_CHR;
                CH_HASH:  s.st = ST_PRE;
                8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h3B, 8'h3A, 8'h2C: begin
                    s.begin_tok = 1'b0;
                    s.emit      = 1'b1;
                end
                default: begin
                    s.begin_tok = 1'b0;
                    s.emit      = 1'b1;
                    s.res       = mk_res(K_ERROR, c, 8'd0, 8'd1, E_UNKNOWN);
                end
            endcase
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/c_subset_lexer.sv =====
`default_nettype none
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tdata: char_code
// m_       out  m_tvalid/m_tready  m_tdata: result fields, m_tlast: last
//
// A plain byte passes through accept, scan step and result hand-off, which
// sends each result in turn. At an identifier end the keyword ROM is walked
// one row per cycle (up to KEYWORD_COUNT) and the symbol memory is read and
// compared row by row over the rows in use through its registered read port.
// Reset clears scanner, counters and the sequencer; the symbol memory needs
// no clearing. A stalled m_tready holds the result and blocks the next byte.
module c_subset_lexer
    import clex_pkg::*;
#(
    parameter int MAX_TOKEN_CHARS = 32,
    parameter int SYMBOL_ENTRIES  = 64,
    parameter int KEYWORD_COUNT   = 28,
    parameter int LINE_BITS       = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,  // [7:0] char_code
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [3:0] token_kind, [11:4] detail_code, [19:12] second_char,
    // [27:20] token_length, [34:28] symbol_index, [35] new_symbol,
    // [39:36] error_code, [55:40] line_number
    output logic [55:0]      m_tdata,
    output logic             m_tlast
);

    localparam int TBW = $clog2(MAX_TOKEN_CHARS);
    localparam int SAW = $clog2(SYMBOL_ENTRIES);
    localparam int SCW = $clog2(SYMBOL_ENTRIES + 1);
    localparam int KWW = $clog2(KEYWORD_COUNT + 1);
    localparam int ROW = MAX_TOKEN_CHARS * 8;

    fsm_t                 fsm_reg, fsm_next;
    scan_t                scan_reg, scan_next;
    logic [7:0]           c_reg;
    logic [LINE_BITS-1:0] line_reg, snap_reg;
    logic [7:0]           tok_buf [MAX_TOKEN_CHARS];
    logic [7:0]           tok_cnt_reg, tok_cnt_next;
    logic [SCW-1:0]       sym_cnt_reg, sym_cnt_next;
    logic [SCW-1:0]       sym_idx_reg, sym_idx_next;
    logic [KWW-1:0]       kw_idx_reg, kw_idx_next;
    res_t                 pend_reg [2];
    res_t                 pend_next [2];
    logic [1:0]           pend_n_reg, pend_n_next;
    logic [1:0]           emit_idx_reg, emit_idx_next;
    res_t                 out_reg;
    logic [LINE_BITS-1:0] out_line_reg;
    logic                 out_valid_reg, out_last_reg;

    logic                 tb_add, tb_begin;
    logic [7:0]           cnt_inc;
    logic [ROW-1:0]       tok_flat;
    logic [ROW-1:0]       rd_row;
    logic [6:0]           rd_len;
    logic                 sym_we;

    // Scan step results
    res_t   s_res;
    logic   s_emit, s_add, s_again, s_ident;
    scan_t  s_st;
    start_t st_info;

    logic [63:0] kw_w;
    logic [3:0]  kw_n;
    logic        kw_hit, row_hit;
    res_t        ins_res;
    logic        ins_ok;
    res_t        err_id;

    assign cnt_inc = (tok_cnt_reg == 8'd255) ? 8'd255 : tok_cnt_reg + 8'd1;
    assign st_info = start_fn(c_reg);

    always_comb begin
        for (int k = 0; k < MAX_TOKEN_CHARS; k++) tok_flat[8*k +: 8] = tok_buf[k];
    end

    // Keyword compare for the current ROM row
    always_comb begin
        kw_w   = kw_word(6'(kw_idx_reg));
        kw_n   = kw_len(kw_w);
        kw_hit = ({4'd0, kw_n} == tok_cnt_reg);
        for (int k = 0; k < 8; k++) begin
            if (4'(k) < kw_n && tok_buf[k] != kw_w[8*(int'(kw_n) - 1 - k) +: 8])
                kw_hit = 1'b0;
        end
    end

    // Symbol row compare
    always_comb begin
        row_hit = ({1'b0, rd_len} == tok_cnt_reg);
        for (int k = 0; k < MAX_TOKEN_CHARS; k++) begin
            if (8'(k) < tok_cnt_reg && rd_row[8*k +: 8] != tok_buf[k]) row_hit = 1'b0;
        end
    end

    // Insert a new symbol, or report a full table
    always_comb begin
        ins_ok        = (sym_cnt_reg < SCW'(SYMBOL_ENTRIES));
        ins_res       = mk_res(K_ID, tok_buf[0], 8'd0, tok_cnt_reg, E_NONE);
        ins_res.sym   = 7'(sym_cnt_reg + SCW'(1));
        ins_res.fresh = 1'b1;
        err_id        = mk_res(K_ERROR, tok_buf[0], 8'd0, tok_cnt_reg, E_OVERFLOW);
        if (!ins_ok) ins_res = err_id;
    end

    // One scanner step on the held byte
    always_comb begin
        s_res   = mk_res(K_NUM, tok_buf[0], 8'd0, tok_cnt_reg, E_NONE);
        s_emit  = 1'b0;
        s_add   = 1'b0;
        s_again = 1'b0;
        s_ident = 1'b0;
        s_st    = ST_START;
        case (scan_reg)
            ST_IDENT: begin
                if (is_word(c_reg)) begin
                    s_add = 1'b1;
                    s_st  = ST_IDENT;
                end else begin
                    s_ident = 1'b1;
                end
            end
            ST_INT, ST_FRAC: begin
                if (is_num(c_reg)) begin
                    s_add = 1'b1;
                    s_st  = scan_reg;
                end else if ((is_alpha(c_reg) || c_reg == CH_UNDER)
                             && c_reg != CH_E_LO && c_reg != CH_E_UP) begin
                    s_add = 1'b1;
                    s_st  = ST_IDENT;
                end else if (scan_reg == ST_INT && c_reg == CH_DOT) begin
                    s_add = 1'b1;
                    s_st  = ST_DOT;
                end else if (c_reg == CH_E_LO || c_reg == CH_E_UP) begin
                    s_add = 1'b1;
                    s_st  = ST_EXP;
                end else begin
                    s_emit  = 1'b1;
                    s_again = 1'b1;
                end
            end
            ST_DOT, ST_EXP, ST_SIGN, ST_EXPD: begin
                if (is_num(c_reg)) begin
                    s_add = 1'b1;
                    s_st  = (scan_reg == ST_DOT) ? ST_FRAC : ST_EXPD;
                end else if (is_alpha(c_reg) || c_reg == CH_UNDER) begin
                    s_add = 1'b1;
                    s_st  = ST_IDENT;
                end else if (scan_reg == ST_EXP && (c_reg == CH_PLUS || c_reg == CH_MINUS)) begin
                    s_add = 1'b1;
                    s_st  = ST_SIGN;
                end else begin
                    s_emit  = 1'b1;
                    s_again = 1'b1;
                    case (scan_reg)
                        ST_DOT:  s_res = mk_res(K_ERROR, tok_buf[0], 8'd0, tok_cnt_reg, E_NO_FRAC);
                        ST_EXP:  s_res = mk_res(K_ERROR, tok_buf[0], 8'd0, tok_cnt_reg, E_NO_EXP);
                        ST_SIGN: s_res = mk_res(K_ERROR, tok_buf[0], 8'd0, tok_cnt_reg, E_BAD_EXP);
                        default: s_res = mk_res(K_NUM, tok_buf[0], 8'd0, tok_cnt_reg, E_NONE);
                    endcase
                end
            end
            ST_LT, ST_GT: begin
                s_emit = 1'b1;
                if (c_reg == tok_buf[0])
                    s_res = mk_res(K_SHIFT, tok_buf[0], c_reg, 8'd2, E_NONE);
                else if (c_reg == CH_EQ)
                    s_res = mk_res(K_RELOP, tok_buf[0], c_reg, 8'd2, E_NONE);
                else begin
                    s_res   = mk_res(K_RELOP, tok_buf[0], 8'd0, tok_cnt_reg, E_NONE);
                    s_again = 1'b1;
                end
            end
            ST_AMP, ST_BAR: begin
                s_emit = 1'b1;
                if (c_reg == tok_buf[0])
                    s_res = mk_res(K_LOGIC, tok_buf[0], c_reg, 8'd2, E_NONE);
                else begin
                    s_again = 1'b1;
                    s_res   = (scan_reg == ST_AMP)
                        ? mk_res(K_ADDR, tok_buf[0], 8'd0, tok_cnt_reg, E_NONE)
                        : mk_res(K_ERROR, tok_buf[0], 8'd0, tok_cnt_reg, E_BAR);
                end
            end
            ST_ARITH, ST_EQ, ST_BANG, ST_SLASH: begin
                if (c_reg == CH_EQ) begin
                    s_emit = 1'b1;
                    s_res  = mk_res((scan_reg == ST_ARITH || scan_reg == ST_SLASH)
                                    ? K_ASSIGN : K_RELOP, tok_buf[0], c_reg, 8'd2, E_NONE);
                end else if (scan_reg == ST_SLASH && (c_reg == CH_SLASH || c_reg == CH_STAR)) begin
                    s_add = 1'b1;
                    s_st  = (c_reg == CH_SLASH) ? ST_LCOM : ST_BCOM;
                end else begin
                    s_emit  = 1'b1;
                    s_again = 1'b1;
                    case (scan_reg)
                        ST_EQ:   s_res = mk_res(K_ASSIGN, tok_buf[0], 8'd0, tok_cnt_reg, E_NONE);
                        ST_BANG: s_res = mk_res(K_ERROR, tok_buf[0], 8'd0, tok_cnt_reg, E_BANG);
                        default: s_res = mk_res(K_OP, tok_buf[0], 8'd0, tok_cnt_reg, E_NONE);
                    endcase
                end
            end
            ST_LCOM, ST_PRE: begin
                if (c_reg == CH_NL) begin
                    s_emit = 1'b1;
                    s_res  = mk_res((scan_reg == ST_LCOM) ? K_COMMENT : K_PRE,
                                    tok_buf[0], 8'd0, tok_cnt_reg, E_NONE);
                end else if (c_reg != CH_NUL) begin
                    s_add = 1'b1;
                    s_st  = scan_reg;
                end
            end
            ST_BCOM, ST_STAR: begin
                if (c_reg != CH_NUL) begin
                    s_add = 1'b1;
                    if (c_reg == CH_STAR) s_st = ST_STAR;
                    else if (c_reg == CH_SLASH && scan_reg == ST_STAR) begin
                        s_emit = 1'b1;
                        s_res  = mk_res(K_COMMENT, tok_buf[0], 8'd0, cnt_inc, E_NONE);
                    end else s_st = ST_BCOM;
                end
            end
            ST_STR, ST_CHR: begin
                if (c_reg != CH_NUL) begin
                    s_add = 1'b1;
                    if (c_reg == ((scan_reg == ST_STR) ? CH_DQ : CH_SQ)) begin
                        s_emit = 1'b1;
                        s_res  = mk_res((scan_reg == ST_STR) ? K_STR : K_CHR,
                                        tok_buf[0], 8'd0, cnt_inc, E_NONE);
                    end else s_st = scan_reg;
                end
            end
            default: begin
                s_emit = st_info.emit;
                s_res  = st_info.res;
                s_st   = st_info.begin_tok ? st_info.st : ST_START;
            end
        endcase
    end

    // Sequencer: scan, keyword walk, symbol search, result hand-off
    always_comb begin
        fsm_next      = fsm_reg;
        scan_next     = scan_reg;
        sym_cnt_next  = sym_cnt_reg;
        sym_idx_next  = sym_idx_reg;
        kw_idx_next   = kw_idx_reg;
        pend_next     = pend_reg;
        pend_n_next   = pend_n_reg;
        emit_idx_next = emit_idx_reg;
        tb_add        = 1'b0;
        tb_begin      = 1'b0;
        sym_we        = 1'b0;
        case (fsm_reg)
            F_IDLE: begin
                if (s_tvalid) fsm_next = F_STEP;
            end
            F_STEP: begin
                emit_idx_next = 2'd0;
                if (s_ident) begin
                    kw_idx_next = '0;
                    fsm_next    = F_KW;
                end else begin
                    pend_next[0] = s_res;
                    pend_n_next  = {1'b0, s_emit};
                    scan_next    = s_st;
                    tb_add       = s_add;
                    if (scan_reg == ST_START) tb_begin = st_info.begin_tok;
                    if (s_again && c_reg != CH_NUL) begin
                        pend_next[s_emit ? 1 : 0] = st_info.res;
                        pend_n_next = 2'({1'b0, s_emit}) + 2'({1'b0, st_info.emit});
                        tb_begin    = st_info.begin_tok;
                        scan_next   = st_info.begin_tok ? st_info.st : ST_START;
                    end
                    fsm_next = F_EMIT;
                end
            end
            F_KW: begin
                if (tok_cnt_reg <= 8'd8 && kw_idx_reg < KWW'(KEYWORD_COUNT)) begin
                    if (kw_hit) begin
                        pend_next[0] = mk_res(K_KW, 8'(kw_idx_reg), 8'd0, tok_cnt_reg, E_NONE);
                        fsm_next     = F_FIN;
                    end else begin
                        kw_idx_next = kw_idx_reg + KWW'(1);
                    end
                end else if (is_num(tok_buf[0])) begin
                    pend_next[0] = mk_res(K_ERROR, tok_buf[0], 8'd0, tok_cnt_reg, E_ID_DIGIT);
                    fsm_next     = F_FIN;
                end else if (tok_cnt_reg > 8'(MAX_TOKEN_CHARS)) begin
                    pend_next[0] = err_id;
                    fsm_next     = F_FIN;
                end else if (sym_cnt_reg != '0) begin
                    sym_idx_next = '0;
                    fsm_next     = F_SRD;
                end else begin
                    pend_next[0] = ins_res;
                    sym_we       = ins_ok;
                    fsm_next     = F_FIN;
                end
            end
            F_SRD: begin
                fsm_next = F_SCMP;
            end
            F_SCMP: begin
                if (row_hit) begin
                    pend_next[0]     = mk_res(K_ID, tok_buf[0], 8'd0, tok_cnt_reg, E_NONE);
                    pend_next[0].sym = 7'(sym_idx_reg + SCW'(1));
                    fsm_next         = F_FIN;
                end else if (sym_idx_reg + SCW'(1) < sym_cnt_reg) begin
                    sym_idx_next = sym_idx_reg + SCW'(1);
                    fsm_next     = F_SRD;
                end else begin
                    pend_next[0] = ins_res;
                    sym_we       = ins_ok;
                    fsm_next     = F_FIN;
                end
            end
            F_FIN: begin
                if (sym_we == 1'b0 && fsm_reg == F_FIN) begin
                    sym_cnt_next = sym_cnt_reg;
                end
                pend_n_next = 2'd1;
                scan_next   = ST_START;
                if (c_reg != CH_NUL) begin
                    pend_next[1] = st_info.res;
                    pend_n_next  = st_info.emit ? 2'd2 : 2'd1;
                    tb_begin     = st_info.begin_tok;
                    if (st_info.begin_tok) scan_next = st_info.st;
                end
                fsm_next = F_EMIT;
            end
            F_EMIT: begin
                if (emit_idx_reg >= pend_n_reg) fsm_next = F_IDLE;
                else if (!out_valid_reg || m_tready) emit_idx_next = emit_idx_reg + 2'd1;
            end
            default: fsm_next = F_IDLE;
        endcase
        if (sym_we) sym_cnt_next = sym_cnt_reg + SCW'(1);
    end

    assign s_tready = (fsm_reg == F_IDLE);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg      <= F_IDLE;
            scan_reg     <= ST_START;
            line_reg     <= LINE_BITS'(1);
            tok_cnt_reg  <= 8'd0;
            sym_cnt_reg  <= '0;
            pend_n_reg   <= 2'd0;
            emit_idx_reg <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            fsm_reg      <= fsm_next;
            scan_reg     <= scan_next;
            tok_cnt_reg  <= tok_cnt_next;
            sym_cnt_reg  <= sym_cnt_next;
            pend_n_reg   <= pend_n_next;
            emit_idx_reg <= emit_idx_next;
            if (s_tvalid && s_tready && s_tdata == CH_NL) line_reg <= line_reg + LINE_BITS'(1);
            if (fsm_reg == F_EMIT && emit_idx_reg < pend_n_reg && (!out_valid_reg || m_tready))
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Token count update
    always_comb begin
        tok_cnt_next = tok_cnt_reg;
        if (tb_begin) tok_cnt_next = 8'd1;
        else if (tb_add) tok_cnt_next = cnt_inc;
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            c_reg    <= s_tdata;
            snap_reg <= line_reg;
        end
        sym_idx_reg <= sym_idx_next;
        kw_idx_reg  <= kw_idx_next;
        pend_reg    <= pend_next;
        if (tb_begin) tok_buf[0] <= c_reg;
        else if (tb_add && tok_cnt_reg < 8'(MAX_TOKEN_CHARS))
            tok_buf[tok_cnt_reg[TBW-1:0]] <= c_reg;
        if (fsm_reg == F_EMIT && emit_idx_reg < pend_n_reg && (!out_valid_reg || m_tready)) begin
            out_reg      <= pend_reg[emit_idx_reg[0]];
            out_line_reg <= snap_reg;
            out_last_reg <= (emit_idx_reg + 2'd1 == pend_n_reg);
        end
    end

    clex_symtab #(
        .ROW_BITS (ROW),
        .ENTRIES  (SYMBOL_ENTRIES)
    ) u_symtab (
        .aclk    (aclk),
        .rd_addr (sym_idx_reg[SAW-1:0]),
        .rd_row  (rd_row),
        .rd_len  (rd_len),
        .wr_en   (sym_we),
        .wr_addr (sym_cnt_reg[SAW-1:0]),
        .wr_row  (tok_flat),
        .wr_len  (7'(tok_cnt_reg))
    );

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {16'(out_line_reg), out_reg.err, out_reg.fresh, out_reg.sym,
                       out_reg.len, out_reg.second, out_reg.detail, out_reg.kind};

endmodule
`default_nettype wire

// ===== rtl/clex_symtab.sv =====
`default_nettype none
module clex_symtab #(
    parameter int ROW_BITS = 256,
    parameter int ENTRIES  = 64
) (
    input  wire logic                        aclk,
    input  wire logic [$clog2(ENTRIES)-1:0]  rd_addr,
    output logic      [ROW_BITS-1:0]         rd_row,
    output logic      [6:0]                  rd_len,
    input  wire logic                        wr_en,
    input  wire logic [$clog2(ENTRIES)-1:0]  wr_addr,
    input  wire logic [ROW_BITS-1:0]         wr_row,
    input  wire logic [6:0]                  wr_len
);

    logic [ROW_BITS-1:0] row_mem [ENTRIES];
    logic [6:0]          len_mem [ENTRIES];

    // Write a new symbol row
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_mem[wr_addr] <= wr_row;
            len_mem[wr_addr] <= wr_len;
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        rd_row <= row_mem[rd_addr];
        rd_len <= len_mem[rd_addr];
    end

endmodule
`default_nettype wire
